[rtl/bts_pkg.sv]
// shared types, constants and helper functions for the board thermal supervisor
package bts_pkg;

    // board count and register file layout
    localparam int NUM_BOARDS_DEF = 3;
    localparam int NUM_LIMITS     = 3;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_LIMIT_ZERO  = 3'd0;
    localparam logic [2:0] REG_LIMIT_ONE   = 3'd1;
    localparam logic [2:0] REG_LIMIT_TWO   = 3'd2;
    localparam logic [2:0] REG_TURN_ON     = 3'd3;
    localparam logic [2:0] REG_COUNT_LIMIT = 3'd4;

    // action codes carried on tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_ROUND  = 1'b1;

    // thresholds and reset values
    localparam logic [6:0] LIMIT_SAFETY     = 7'd95;
    localparam logic [7:0] TURN_ON_RESET    = 8'd60;
    localparam logic [7:0] COUNT_LIMIT_RST  = 8'd4;
    localparam logic [7:0] TEMP_VALID_MIN   = 8'd1;
    localparam logic [7:0] TEMP_VALID_MAX   = 8'd149;
    localparam logic [7:0] COUNT_MAX        = 8'd255;
    localparam logic [7:0] TEMP_RESET       = 8'd90;
    localparam logic [3:0] BOARD_FAN_RESET  = 4'd1;
    localparam logic [3:0] SHARED_FAN_RESET = 4'd6;
    localparam logic [3:0] FAN_MIN_LEVEL    = 4'd1;
    localparam logic [3:0] FAN_MAX_LEVEL    = 4'd10;
    localparam int         FAN_LOW_TEMP     = 30;
    localparam int         FAN_STEP_TEMP    = 5;
    localparam int         FAN_STEPS        = 9;

    // input item fields carried in tdata, lowest field last
    typedef struct packed {
        logic [7:0] chip_raw;
        logic [7:0] board_raw;
        logic       read_ack;
        logic [1:0] board_index;
    } in_item_t;

    // result item fields carried in tdata, lowest field last
    typedef struct packed {
        logic [2:0] connected_mask;
        logic       fan_write;
        logic [3:0] fan_speed;
        logic       power_write;
        logic [2:0] power_mask;
    } result_t;

    // fan level from chip temperature: 1 below 30, one more per 5 degrees, 10 from 70
    function automatic logic [3:0] fan_from_chip(input logic [7:0] chip);
        logic [3:0] lvl;
        lvl = FAN_MIN_LEVEL;
        for (int k = 0; k < FAN_STEPS; k++)
        begin
            if (chip >= 8'(FAN_LOW_TEMP + FAN_STEP_TEMP * k))
            begin
                lvl = lvl + 4'd1;
            end
        end
        return lvl;
    endfunction

endpackage

[rtl/board_thermal_supervisor.sv]
// board thermal supervisor top level: sample and round handling, register port
//
// Each input beat gives exactly one result beat. A beat is captured in an input
// register and processed from there in a single pass of compares and a
// three-way maximum, which updates the per-board state and loads the result
// register in the same edge; while the result stream does not stall, a new beat
// is taken every cycle, so throughput is one item per clock. The output register
// stalls the input register only while the result is not taken. Configuration
// writes through the register port must happen while no beat is in flight; a
// limit write whose low seven bits exceed 95 is ignored.
module board_thermal_supervisor #(
    parameter int NUM_BOARDS = bts_pkg::NUM_BOARDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // board_index[1:0], read_ack[2], board_raw[10:3], chip_raw[18:11], zero fill
    input  logic [23:0]                 s_tdata,
    // action[0]
    input  logic                        s_tuser,
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // power_mask[2:0], power_write[3], fan_speed[7:4], fan_write[8],
    // connected_mask[11:9], zero fill
    output logic [15:0]                 m_tdata,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bts_pkg::ADDR_W-1:0]  paddr,
    input  logic [bts_pkg::DATA_W-1:0]  pwdata,
    output logic [bts_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bts_pkg::*;

    // configuration registers
    logic [6:0] limit_reg [NUM_LIMITS];
    logic [7:0] turn_on_reg;
    logic [7:0] count_limit_reg;
    logic       cfg_write;
    logic [2:0] cfg_index;

    // input and result stages
    logic       in_valid_reg;
    logic       in_action_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       fire;

    // per-board state
    logic [7:0]            btemp_reg  [NUM_BOARDS];
    logic [7:0]            ctemp_reg  [NUM_BOARDS];
    logic [3:0]            bfan_reg   [NUM_BOARDS];
    logic [7:0]            count_reg  [NUM_BOARDS];
    logic [NUM_BOARDS-1:0] conn_reg;
    logic [NUM_BOARDS-1:0] enable_reg;
    logic [3:0]            fan_reg;

    // next values
    logic [7:0]            btemp_next [NUM_BOARDS];
    logic [7:0]            ctemp_next [NUM_BOARDS];
    logic [3:0]            bfan_next  [NUM_BOARDS];
    logic [7:0]            count_next [NUM_BOARDS];
    logic [NUM_BOARDS-1:0] conn_next;
    logic [NUM_BOARDS-1:0] enable_next;
    logic [3:0]            fan_next;
    logic                  fan_write;
    logic                  sample_ok;
    logic                  new_over;
    logic                  stored_over;
    logic                  any_conn;
    logic [3:0]            max_fan;
    result_t               result_next;

    // register port
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LIMITS; i++)
            begin
                limit_reg[i] <= LIMIT_SAFETY;
            end
            turn_on_reg     <= TURN_ON_RESET;
            count_limit_reg <= COUNT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LIMIT_ZERO, REG_LIMIT_ONE, REG_LIMIT_TWO:
                begin
                    if (pwdata[6:0] <= LIMIT_SAFETY)
                    begin
                        limit_reg[cfg_index[1:0]] <= pwdata[6:0];
                    end
                end
                REG_TURN_ON:     turn_on_reg     <= pwdata[7:0];
                REG_COUNT_LIMIT: count_limit_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_index)
            REG_LIMIT_ZERO:  prdata = DATA_W'(limit_reg[0]);
            REG_LIMIT_ONE:   prdata = DATA_W'(limit_reg[1]);
            REG_LIMIT_TWO:   prdata = DATA_W'(limit_reg[2]);
            REG_TURN_ON:     prdata = DATA_W'(turn_on_reg);
            REG_COUNT_LIMIT: prdata = DATA_W'(count_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser;
            in_item_reg   <= in_item_t'(s_tdata[18:0]);
        end
    end

    // sample validity
    assign sample_ok = in_item_reg.read_ack
                    && in_item_reg.board_raw >= TEMP_VALID_MIN
                    && in_item_reg.board_raw <= TEMP_VALID_MAX
                    && in_item_reg.chip_raw  >= TEMP_VALID_MIN
                    && in_item_reg.chip_raw  <= TEMP_VALID_MAX;

    // single pass over the boards
    always_comb
    begin
        conn_next   = conn_reg;
        enable_next = enable_reg;
        fan_next    = fan_reg;
        fan_write   = 1'b0;
        any_conn    = 1'b0;
        max_fan     = '0;
        new_over    = 1'b0;
        stored_over = 1'b0;
        for (int i = 0; i < NUM_BOARDS; i++)
        begin
            btemp_next[i] = btemp_reg[i];
            ctemp_next[i] = ctemp_reg[i];
            bfan_next[i]  = bfan_reg[i];
            count_next[i] = count_reg[i];
            if (in_action_reg == ACT_SAMPLE)
            begin
                // sample report for the addressed board
                if (in_item_reg.board_index == 2'(i))
                begin
                    if (sample_ok)
                    begin
                        new_over = in_item_reg.board_raw > {1'b0, limit_reg[i]}
                                || in_item_reg.chip_raw  > {1'b0, limit_reg[i]};
                        btemp_next[i] = in_item_reg.board_raw;
                        ctemp_next[i] = in_item_reg.chip_raw;
                        bfan_next[i]  = fan_from_chip(in_item_reg.chip_raw);
                        conn_next[i]  = 1'b1;
                        if (!new_over)
                        begin
                            count_next[i] = '0;
                        end
                        else if (count_reg[i] != COUNT_MAX)
                        begin
                            count_next[i] = count_reg[i] + 8'd1;
                        end
                    end
                    else
                    begin
                        conn_next[i] = 1'b0;
                    end
                end
            end
            else
            begin
                // end of round: power decision and running fan maximum
                stored_over = btemp_reg[i] > {1'b0, limit_reg[i]}
                           || ctemp_reg[i] > {1'b0, limit_reg[i]};
                if (conn_reg[i] && stored_over && count_reg[i] > count_limit_reg)
                begin
                    enable_next[i] = 1'b0;
                end
                else if (conn_reg[i] && btemp_reg[i] < turn_on_reg)
                begin
                    enable_next[i] = 1'b1;
                end
                if (conn_reg[i])
                begin
                    if (!any_conn || bfan_reg[i] > max_fan)
                    begin
                        max_fan = bfan_reg[i];
                    end
                    any_conn = 1'b1;
                end
            end
        end
        if (in_action_reg == ACT_ROUND && any_conn && max_fan != fan_reg)
        begin
            fan_next  = max_fan;
            fan_write = 1'b1;
        end
    end

    // result of this beat
    always_comb
    begin
        result_next.power_mask     = 3'(enable_next);
        result_next.power_write    = (in_action_reg == ACT_ROUND);
        result_next.fan_speed      = fan_next;
        result_next.fan_write      = fan_write;
        result_next.connected_mask = 3'(conn_next);
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOARDS; i++)
            begin
                btemp_reg[i] <= TEMP_RESET;
                ctemp_reg[i] <= TEMP_RESET;
                bfan_reg[i]  <= BOARD_FAN_RESET;
                count_reg[i] <= '0;
            end
            conn_reg   <= '0;
            enable_reg <= '0;
            fan_reg    <= SHARED_FAN_RESET;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_BOARDS; i++)
            begin
                btemp_reg[i] <= btemp_next[i];
                ctemp_reg[i] <= ctemp_next[i];
                bfan_reg[i]  <= bfan_next[i];
                count_reg[i] <= count_next[i];
            end
            conn_reg   <= conn_next;
            enable_reg <= enable_next;
            fan_reg    <= fan_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg};

    // shared fan level never leaves its range
    assert property (@(posedge clk) disable iff (!rst_n)
        fan_reg >= FAN_MIN_LEVEL && fan_reg <= FAN_MAX_LEVEL)
        else $error("shared fan level out of range");

    // a fan write only comes with an end-of-round result
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && fan_write |-> in_action_reg == ACT_ROUND)
        else $error("fan write on a sample beat");

    // a held input beat stays put while the result register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg)
            && $stable(in_action_reg))
        else $error("input stage lost a beat under stall");

    // a sample beat never touches the power mask
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_action_reg == ACT_SAMPLE |=> $stable(enable_reg))
        else $error("power mask changed on a sample beat");

endmodule

[tb/tb_board_thermal_supervisor.sv]
// testbench for board_thermal_supervisor: directed rows, shaped random polling rounds, scoreboard
module tb_board_thermal_supervisor;
    import bts_pkg::*;

    localparam int BOARDS      = 3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int HOLD_CYCLES = 64;

    // one input item as the block sees it
    typedef struct packed {
        logic       action;
        logic [1:0] board_index;
        logic       read_ack;
        logic [7:0] board_raw;
        logic [7:0] chip_raw;
    } report_t;

    // directed row, with an optional result typed in by hand
    typedef struct {
        report_t item;
        bit      known_ok;
        result_t known_res;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // board_index[1:0], read_ack[2], board_raw[10:3], chip_raw[18:11], zero fill
    logic [23:0]         s_tdata;
    // action[0]
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // power_mask[2:0], power_write[3], fan_speed[7:4], fan_write[8],
    // connected_mask[11:9], zero fill
    logic [15:0]         m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predicted supervisor state and register shadow
    logic [7:0] brd_temp [BOARDS] = '{TEMP_RESET, TEMP_RESET, TEMP_RESET};
    logic [7:0] die_temp [BOARDS] = '{TEMP_RESET, TEMP_RESET, TEMP_RESET};
    logic [3:0] brd_fan [BOARDS] = '{BOARD_FAN_RESET, BOARD_FAN_RESET, BOARD_FAN_RESET};
    logic [7:0] over_cnt [BOARDS] = '{8'd0, 8'd0, 8'd0};
    logic [2:0] conn_bits = 3'd0;
    logic [2:0] enab_bits = 3'd0;
    logic [3:0] fan_now = SHARED_FAN_RESET;
    logic [6:0] lim [BOARDS] = '{LIMIT_SAFETY, LIMIT_SAFETY, LIMIT_SAFETY};
    logic [7:0] turn_on = TURN_ON_RESET;
    logic [7:0] cnt_lim = COUNT_LIMIT_RST;

    // status beats still owed by the block, oldest first
    result_t status_q [$];

    int fails = 0;
    int gap_max = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int hold_asked = 0;
    int hold_served = 0;

    board_thermal_supervisor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // fan level a board asks for at a given chip temperature
    function automatic logic [3:0] fan_step_for(input logic [7:0] chip);
        if (chip >= 8'd70)
            return FAN_MAX_LEVEL;
        if (chip < 8'd30)
            return FAN_MIN_LEVEL;
        return 4'((chip - 8'd30) / 8'd5 + 8'd2);
    endfunction

    function automatic bit runs_hot(input int b);
        return brd_temp[b] > {1'b0, lim[b]} || die_temp[b] > {1'b0, lim[b]};
    endfunction

    // advance the predicted state by one item and return the status it causes
    function automatic result_t next_status(input report_t r);
        result_t    res;
        logic [3:0] top;
        bit         any;
        int         i;
        res = '0;
        any = 1'b0;
        top = 4'd0;
        i = r.board_index;
        if (r.action == ACT_SAMPLE)
        begin
            if (i < BOARDS)
            begin
                if (r.read_ack && r.board_raw >= TEMP_VALID_MIN && r.board_raw <= TEMP_VALID_MAX
                    && r.chip_raw >= TEMP_VALID_MIN && r.chip_raw <= TEMP_VALID_MAX)
                begin
                    brd_temp[i] = r.board_raw;
                    die_temp[i] = r.chip_raw;
                    brd_fan[i] = fan_step_for(r.chip_raw);
                    conn_bits[i] = 1'b1;
                    // consecutive over-limit count, saturating
                    if (runs_hot(i))
                    begin
                        if (over_cnt[i] != COUNT_MAX)
                            over_cnt[i] = over_cnt[i] + 8'd1;
                    end
                    else
                    begin
                        over_cnt[i] = 8'd0;
                    end
                end
                else
                begin
                    conn_bits[i] = 1'b0;
                end
            end
        end
        else
        begin
            res.power_write = 1'b1;
            for (int b = 0; b < BOARDS; b++)
            begin
                if (conn_bits[b] && runs_hot(b) && over_cnt[b] > cnt_lim)
                    enab_bits[b] = 1'b0;
                else if (conn_bits[b] && brd_temp[b] < turn_on)
                    enab_bits[b] = 1'b1;
                if (conn_bits[b])
                begin
                    if (!any || brd_fan[b] > top)
                        top = brd_fan[b];
                    any = 1'b1;
                end
            end
            if (any && top != fan_now)
            begin
                fan_now = top;
                res.fan_write = 1'b1;
            end
        end
        res.power_mask = enab_bits;
        res.fan_speed = fan_now;
        res.connected_mask = conn_bits;
        return res;
    endfunction

    function automatic dir_row_t sample_row(input logic [1:0] idx, input logic ack,
                                            input logic [7:0] brd, input logic [7:0] chip);
        dir_row_t row;
        row.item.action = ACT_SAMPLE;
        row.item.board_index = idx;
        row.item.read_ack = ack;
        row.item.board_raw = brd;
        row.item.chip_raw = chip;
        row.known_ok = 1'b0;
        row.known_res = '0;
        return row;
    endfunction

    function automatic dir_row_t round_row();
        dir_row_t row;
        row.item = '0;
        row.item.action = ACT_ROUND;
        row.known_ok = 1'b0;
        row.known_res = '0;
        return row;
    endfunction

    function automatic dir_row_t with_result(input dir_row_t row, input logic [2:0] mask,
                                             input logic [3:0] fan, input logic fw,
                                             input logic [2:0] conn);
        dir_row_t out_row;
        out_row = row;
        out_row.known_ok = 1'b1;
        out_row.known_res.power_mask = mask;
        out_row.known_res.power_write = row.item.action;
        out_row.known_res.fan_speed = fan;
        out_row.known_res.fan_write = fw;
        out_row.known_res.connected_mask = conn;
        return out_row;
    endfunction

    // present one item until taken, log what it owes, then maybe end the burst
    task automatic offer(input report_t r, input bit known_ok, input result_t known_res);
        result_t pred;
        s_tvalid <= 1'b1;
        s_tuser <= r.action;
        s_tdata <= {5'd0, r.chip_raw, r.board_raw, r.read_ack, r.board_index};
        do
            @(posedge clk);
        while (!s_tready);
        pred = next_status(r);
        status_q.push_back(known_ok ? known_res : pred);
        if (gap_max != 0)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // stop offering and let every owed status beat drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, shadow update, then read back
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] want;
        want = '0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_LIMIT_ZERO, REG_LIMIT_ONE, REG_LIMIT_TWO:
            begin
                // limits whose low seven bits exceed the safety value are refused
                if (val[6:0] <= LIMIT_SAFETY)
                    lim[idx] = val[6:0];
                want = 32'(lim[idx]);
            end
            REG_TURN_ON:
            begin
                turn_on = val[7:0];
                want = 32'(turn_on);
            end
            REG_COUNT_LIMIT:
            begin
                cnt_lim = val[7:0];
                want = 32'(cnt_lim);
            end
            default:
            begin
                want = '0;
            end
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            fails++;
            $error("register %0d readback: expected %0d, got %0d", idx, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(12 * 400000);
        $display("** board_thermal_supervisor: FAILED **");
        $finish;
    end

    // result side: own stall pattern plus an occasional long hold-off
    initial
    begin : rx_side
        int tick;
        tick = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) >= 3);
                2:       m_tready <= ((tick % 7) >= 3);
                default: m_tready <= ($urandom_range(0, 9) >= 7);
            endcase
        end
    end

    // scoreboard on every accepted status beat
    always @(posedge clk)
    begin : status_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[11:0]);
            if (status_q.size() == 0)
            begin
                fails++;
                $error("status beat with nothing owed: %h", m_tdata);
            end
            else
            begin
                want = status_q.pop_front();
                if (got.power_mask !== want.power_mask)
                begin
                    fails++;
                    $error("power_mask: expected %0d, got %0d", want.power_mask, got.power_mask);
                end
                if (got.power_write !== want.power_write)
                begin
                    fails++;
                    $error("power_write: expected %0d, got %0d", want.power_write,
                           got.power_write);
                end
                if (got.fan_speed !== want.fan_speed)
                begin
                    fails++;
                    $error("fan_speed: expected %0d, got %0d", want.fan_speed, got.fan_speed);
                end
                if (got.fan_write !== want.fan_write)
                begin
                    fails++;
                    $error("fan_write: expected %0d, got %0d", want.fan_write, got.fan_write);
                end
                if (got.connected_mask !== want.connected_mask)
                begin
                    fails++;
                    $error("connected_mask: expected %0d, got %0d", want.connected_mask,
                           got.connected_mask);
                end
                if (m_tdata[15:12] !== 4'd0)
                begin
                    fails++;
                    $error("tdata fill: expected 0, got %0d", m_tdata[15:12]);
                end
            end
        end
    end

    // stimulus: directed rows, then phases of polling rounds under changing limits
    initial
    begin : tx_side
        dir_row_t dir_tab [$];
        report_t  r;
        int       heat [BOARDS];
        int       sent;
        int       pick;
        int       c;

        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // round with nothing connected keeps the reset fan level
        dir_tab.push_back(with_result(round_row(), 3'd0, 4'd6, 1'b0, 3'd0));
        // lowest and highest valid temperatures
        dir_tab.push_back(with_result(sample_row(2'd0, 1'b1, 8'd1, 8'd1), 3'd0, 4'd6, 1'b0, 3'd1));
        dir_tab.push_back(with_result(sample_row(2'd1, 1'b1, 8'd149, 8'd149), 3'd0, 4'd6, 1'b0,
                                      3'd3));
        // no acknowledge
        dir_tab.push_back(with_result(sample_row(2'd2, 1'b0, 8'd50, 8'd50), 3'd0, 4'd6, 1'b0,
                                      3'd3));
        dir_tab.push_back(with_result(round_row(), 3'd1, 4'd10, 1'b1, 3'd3));
        // temperatures just outside the valid range
        dir_tab.push_back(sample_row(2'd2, 1'b1, 8'd0, 8'd50));
        dir_tab.push_back(sample_row(2'd2, 1'b1, 8'd150, 8'd50));
        dir_tab.push_back(sample_row(2'd2, 1'b1, 8'd50, 8'd0));
        dir_tab.push_back(sample_row(2'd2, 1'b1, 8'd255, 8'd255));
        // board index out of range is ignored
        dir_tab.push_back(with_result(sample_row(2'd3, 1'b1, 8'd50, 8'd50), 3'd1, 4'd10, 1'b0,
                                      3'd3));
        // hot chip on a cool board: powered on first, off once the count is exceeded
        dir_tab.push_back(sample_row(2'd1, 1'b1, 8'd40, 8'd100));
        dir_tab.push_back(round_row());
        repeat (4) dir_tab.push_back(sample_row(2'd1, 1'b1, 8'd40, 8'd100));
        dir_tab.push_back(round_row());
        // fan level edges
        dir_tab.push_back(sample_row(2'd1, 1'b0, 8'd0, 8'd0));
        dir_tab.push_back(sample_row(2'd0, 1'b1, 8'd20, 8'd29));
        dir_tab.push_back(round_row());
        dir_tab.push_back(sample_row(2'd0, 1'b1, 8'd20, 8'd30));
        dir_tab.push_back(round_row());
        dir_tab.push_back(sample_row(2'd0, 1'b1, 8'd20, 8'd69));
        dir_tab.push_back(round_row());
        dir_tab.push_back(sample_row(2'd0, 1'b1, 8'd20, 8'd70));
        dir_tab.push_back(sample_row(2'd2, 1'b1, 8'd60, 8'd34));
        dir_tab.push_back(round_row());

        gap_max = 3;
        rx_mode = 1;
        foreach (dir_tab[k])
            offer(dir_tab[k].item, dir_tab[k].known_ok, dir_tab[k].known_res);

        for (int b = 0; b < BOARDS; b++)
            heat[b] = $urandom_range(1, 149);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    // everything over limit, immediate power-off, turn-on condition always met
                    write_reg(REG_LIMIT_ZERO, 32'd0);
                    write_reg(REG_LIMIT_ONE, 32'd0);
                    write_reg(REG_LIMIT_TWO, 32'd0);
                    write_reg(REG_TURN_ON, 32'd255);
                    write_reg(REG_COUNT_LIMIT, 32'd0);
                end
                1:
                begin
                    // refused limit write keeps the old value
                    write_reg(REG_LIMIT_ZERO, 32'd95);
                    write_reg(REG_LIMIT_ONE, 32'd95);
                    write_reg(REG_LIMIT_TWO, 32'd127);
                    write_reg(REG_TURN_ON, 32'd0);
                    write_reg(REG_COUNT_LIMIT, 32'd254);
                end
                2:
                begin
                    // upper data bits dropped; a count limit of 255 never powers off
                    write_reg(REG_LIMIT_ZERO, 32'd96);
                    write_reg(REG_LIMIT_ONE, 32'd70);
                    write_reg(REG_LIMIT_TWO, 32'h0000_0085);
                    write_reg(REG_TURN_ON, 32'hFFFF_FF64);
                    write_reg(REG_COUNT_LIMIT, 32'd255);
                end
                3:
                begin
                    write_reg(REG_LIMIT_ZERO, 32'd60);
                    write_reg(REG_LIMIT_ONE, 32'd80);
                    write_reg(REG_LIMIT_TWO, 32'd95);
                    write_reg(REG_TURN_ON, 32'd60);
                    write_reg(REG_COUNT_LIMIT, 32'd1);
                end
                default:
                begin
                    write_reg(REG_LIMIT_ZERO, $urandom_range(0, 127));
                    write_reg(REG_LIMIT_ONE, $urandom_range(0, 127));
                    write_reg(REG_LIMIT_TWO, $urandom_range(0, 127));
                    write_reg(REG_TURN_ON, $urandom_range(0, 255));
                    write_reg(REG_COUNT_LIMIT, $urandom_range(0, 8));
                end
            endcase
            @(posedge clk);

            rx_mode = ph % 4;
            gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 10);
            burst_left = 0;
            // long result stall while items keep coming
            if (ph % 3 == 1)
                hold_asked++;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 82)
                begin
                    // one polling round: a report for each board not skipped at random, then end of round
                    for (int b = 0; b < BOARDS; b++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            continue;
                        heat[b] = heat[b] + int'($urandom_range(0, 16)) - 8;
                        if (heat[b] < 1)
                            heat[b] = 1;
                        if (heat[b] > 149)
                            heat[b] = 149;
                        c = heat[b] + int'($urandom_range(0, 12));
                        if (c > 149)
                            c = 149;
                        r.action = ACT_SAMPLE;
                        r.board_index = 2'(b);
                        r.read_ack = 1'b1;
                        r.board_raw = 8'(heat[b]);
                        r.chip_raw = 8'(c);
                        pick = $urandom_range(0, 19);
                        case (pick)
                            0:
                            begin
                                r.read_ack = 1'b0;
                                r.board_raw = 8'($urandom);
                                r.chip_raw = 8'($urandom);
                            end
                            1: r.board_raw = $urandom_range(0, 1) ? 8'd0
                                                                  : 8'($urandom_range(150, 255));
                            2: r.chip_raw = $urandom_range(0, 1) ? 8'd0
                                                                 : 8'($urandom_range(150, 255));
                            3:
                            begin
                                r.board_raw = 8'($urandom_range(1, 149));
                                r.chip_raw = 8'($urandom_range(1, 149));
                            end
                            4: heat[b] = $urandom_range(1, 149);
                            default: ;
                        endcase
                        offer(r, 1'b0, '0);
                        sent++;
                    end
                    r = report_t'(20'($urandom));
                    r.action = ACT_ROUND;
                    offer(r, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // stray item with any field values
                    r = report_t'(20'($urandom));
                    offer(r, 1'b0, '0);
                    if (!(r.action == ACT_SAMPLE && r.board_index == 2'd3))
                        sent++;
                end
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (fails == 0)
            $display("** board_thermal_supervisor: PASSED **");
        else
            $display("** board_thermal_supervisor: FAILED **");
        $finish;
    end

endmodule
